>>> hdl/s5p_pkg.sv
package s5p_pkg;

   // Protocol constants
   localparam logic [7:0] SOCKS_VERSION = 8'd5;
   localparam logic [7:0] AUTH_NONE     = 8'd0;
   localparam logic [7:0] ATYPE_IPV4    = 8'd1;
   localparam logic [7:0] ATYPE_DOMAIN  = 8'd3;
   localparam logic [7:0] ATYPE_IPV6    = 8'd4;

   localparam int IDX_W = 9;

   // Reply lengths: header, address and port bytes
   localparam logic [IDX_W-1:0] HEADER_LEN = 9'd4;
   localparam logic [IDX_W-1:0] IPV4_TOTAL = 9'd10;  // header + 4 + port
   localparam logic [IDX_W-1:0] IPV6_TOTAL = 9'd22;  // header + 16 + port
   localparam logic [IDX_W-1:0] DOM_BASE   = 9'd7;   // header + length byte + port
   localparam logic [IDX_W-1:0] DOM_FIRST  = 9'd5;   // index after the length byte

   // Header byte positions
   localparam logic [IDX_W-1:0] IDX_VER   = 9'd0;
   localparam logic [IDX_W-1:0] IDX_REPLY = 9'd1;
   localparam logic [IDX_W-1:0] IDX_RSV   = 9'd2;

   // Result status codes
   typedef enum logic [3:0] {
      ST_WAIT   = 4'd0,
      ST_AUTH   = 4'd1,
      ST_CONN   = 4'd2,
      ST_DATA   = 4'd3,
      ST_BADVER = 4'd4,
      ST_NOAUTH = 4'd5,
      ST_REPLY  = 4'd6,
      ST_RSV    = 4'd7,
      ST_ATYPE  = 4'd8
   } status_type;

   // Parser phases, one-hot
   typedef enum logic [5:0] {
      PH_METHOD = 6'b000001,
      PH_HEADER = 6'b000010,
      PH_DOMLEN = 6'b000100,
      PH_SKIP   = 6'b001000,
      PH_DATA   = 6'b010000,
      PH_ERROR  = 6'b100000
   } phase_type;

   // One result
   typedef struct packed {
      status_type status;
      logic [7:0] data;
   } result_type;

endpackage

>>> hdl/socks5_client_reply_parser.sv
// Channel   Ports                              Width  Direction
// request   req_valid req_ready req_rx_byte    8      in
// result    rsp_valid rsp_ready rsp_status     4      out
//           rsp_data_out                       8      out
//
// One byte per cycle sustained while the result side accepts; every request gives exactly one result.
// A byte passes the input register, then parse logic into the result register.
// Synchronous active-high reset returns the parser to awaiting the method reply.
// A stalled result holds the result register and a full input register; the parser
// state advances only when a byte moves from the input to the result register.
module socks5_client_reply_parser (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_status,
   output logic [7:0] rsp_data_out
);
   import s5p_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   result_type result_in;
   logic       out_free;
   logic       advance;

   // Pipeline flow control
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   s5p_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (result_in)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_status   = out_ff.status;
   assign rsp_data_out = out_ff.data;

   // Back-pressure only when both registers are full
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff))
      else $error("request stalled with a free stage");

   // Data byte only carried with data status
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DATA) |-> (rsp_data_out == 8'd0))
      else $error("data byte outside data status");

   // An error code repeats on every later result
   a_err_latch: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && (rsp_status == ST_BADVER || rsp_status == ST_NOAUTH ||
       rsp_status == ST_REPLY || rsp_status == ST_RSV || rsp_status == ST_ATYPE))
      |=> (!rsp_valid || rsp_status == $past(rsp_status)))
      else $error("latched error changed");

endmodule

>>> hdl/s5p_parse.sv
module s5p_parse (
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic [7:0]         rx_byte,
   output s5p_pkg::result_type result
);
   import s5p_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [IDX_W-1:0] byte_index_ff, byte_index_in;
   logic [IDX_W-1:0] reply_total_ff, reply_total_in;
   status_type       latched_error_ff, latched_error_in;
   logic [IDX_W:0]   index_inc;

   assign index_inc = {1'b0, byte_index_ff} + {{IDX_W{1'b0}}, 1'b1};

   // Next state and result for the byte at the input register
   always_comb begin
      phase_in         = phase_ff;
      byte_index_in    = byte_index_ff;
      reply_total_in   = reply_total_ff;
      latched_error_in = latched_error_ff;
      result.status    = ST_WAIT;
      result.data      = 8'd0;
      case (phase_ff)
         PH_METHOD: begin
            if (byte_index_ff == IDX_VER) begin
               if (rx_byte != SOCKS_VERSION) begin
                  result.status    = ST_BADVER;
                  latched_error_in = ST_BADVER;
                  phase_in         = PH_ERROR;
               end else begin
                  byte_index_in = IDX_REPLY;
               end
            end else if (rx_byte != AUTH_NONE) begin
               result.status    = ST_NOAUTH;
               latched_error_in = ST_NOAUTH;
               phase_in         = PH_ERROR;
            end else begin
               result.status = ST_AUTH;
               phase_in      = PH_HEADER;
               byte_index_in = IDX_VER;
            end
         end
         PH_HEADER: begin
            if (byte_index_ff == IDX_VER) begin
               if (rx_byte != SOCKS_VERSION) begin
                  result.status    = ST_BADVER;
                  latched_error_in = ST_BADVER;
                  phase_in         = PH_ERROR;
               end else begin
                  byte_index_in = IDX_REPLY;
               end
            end else if (byte_index_ff == IDX_REPLY) begin
               if (rx_byte != 8'd0) begin
                  result.status    = ST_REPLY;
                  latched_error_in = ST_REPLY;
                  phase_in         = PH_ERROR;
               end else begin
                  byte_index_in = IDX_RSV;
               end
            end else if (byte_index_ff == IDX_RSV) begin
               if (rx_byte != 8'd0) begin
                  result.status    = ST_RSV;
                  latched_error_in = ST_RSV;
                  phase_in         = PH_ERROR;
               end else begin
                  byte_index_in = index_inc[IDX_W-1:0];
               end
            end else begin
               // address type byte
               byte_index_in = HEADER_LEN;
               if (rx_byte == ATYPE_IPV4) begin
                  reply_total_in = IPV4_TOTAL;
                  phase_in       = PH_SKIP;
               end else if (rx_byte == ATYPE_IPV6) begin
                  reply_total_in = IPV6_TOTAL;
                  phase_in       = PH_SKIP;
               end else if (rx_byte == ATYPE_DOMAIN) begin
                  phase_in = PH_DOMLEN;
               end else begin
                  result.status    = ST_ATYPE;
                  latched_error_in = ST_ATYPE;
                  phase_in         = PH_ERROR;
               end
            end
         end
         PH_DOMLEN: begin
            reply_total_in = DOM_BASE + {1'b0, rx_byte};
            byte_index_in  = DOM_FIRST;
            phase_in       = PH_SKIP;
         end
         PH_SKIP: begin
            // last port byte ends the connect reply
            if (index_inc >= {1'b0, reply_total_ff}) begin
               result.status = ST_CONN;
               phase_in      = PH_DATA;
               byte_index_in = IDX_VER;
            end else begin
               byte_index_in = index_inc[IDX_W-1:0];
            end
         end
         PH_DATA: begin
            result.status = ST_DATA;
            result.data   = rx_byte;
         end
         default: begin
            result.status = latched_error_ff;
         end
      endcase
   end

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_METHOD;
         byte_index_ff    <= '0;
         reply_total_ff   <= '0;
         latched_error_ff <= ST_WAIT;
      end else if (step_en) begin
         phase_ff         <= phase_in;
         byte_index_ff    <= byte_index_in;
         reply_total_ff   <= reply_total_in;
         latched_error_ff <= latched_error_in;
      end
   end

endmodule
